// ===== hw/rtl/sfe_pkg.sv =====
// Shared types and constants for the stereo-to-mono feedback echo.
// No dependencies; imported by every module of the block except sfe_queue.
`timescale 1ns / 1ps

package sfe_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int DELAY_W    = 18;
  localparam int GAIN_W     = 9;
  localparam int CFG_DATA_W = 18;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 9'd102;
  localparam logic [GAIN_W-1:0] GAIN_UNITY = 9'd256;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_DELAY = 1'b0,
    CFG_GAIN  = 1'b1
  } sfe_reg_t;

  typedef struct packed {
    logic                  we;
    sfe_reg_t              index;
    logic [CFG_DATA_W-1:0] data;
  } sfe_cfg_t;

  // Per-word control carried through the queue
  typedef struct packed {
    logic is_left;     // left word: fetch delayed sample; right word: mix and write
    logic fetch_zero;  // fetch must read as zero (before fill or never written)
  } sfe_ctl_t;

endpackage

// ===== hw/rtl/sfe_front.sv =====
// Front end: accepts input words, pairs left/right, builds fetch and write requests.
// Depends on sfe_pkg.
`timescale 1ns / 1ps

module sfe_front #(
  parameter int BUFFER_DEPTH = 262144,
  parameter int AW           = $clog2(BUFFER_DEPTH)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  sfe_pkg::sfe_cfg_t                   cfg,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [sfe_pkg::SAMPLE_W-1:0] sample,
  input  logic                                q_full,
  output logic                                push,
  output sfe_pkg::sfe_ctl_t                   ctl,
  output logic signed [sfe_pkg::SAMPLE_W-1:0] data,
  output logic [AW-1:0]                       addr
);
  import sfe_pkg::*;

  // delay mod depth by restoring subtraction, one shifted depth per cycle
  localparam int KTOP  = (DELAY_W > AW) ? DELAY_W - AW : 0;
  localparam int STEPS = KTOP + 1;
  localparam int SW    = $clog2(STEPS + 1);
  localparam int CW    = AW + KTOP + 1;
  localparam int IW    = (AW > DELAY_W) ? AW + 1 : DELAY_W + 1;

  logic [DELAY_W-1:0]         delay_samples;
  logic [CW-1:0]              red;
  logic [SW-1:0]              step;
  logic [CW-1:0]              step_const;
  logic                       expect_left;
  logic signed [SAMPLE_W-1:0] held_left;
  logic [AW-1:0]              write_index;
  logic                       filled_once;
  logic                       wrapped;

  logic                       busy;
  logic                       acc;
  logic [AW:0]                ia;
  logic [AW:0]                da;
  logic [AW:0]                fetch;
  logic                       before_fill;
  logic                       unwritten;
  logic signed [SAMPLE_W:0]   sum;
  logic signed [SAMPLE_W:0]   sum_adj;

  assign step_const = CW'(BUFFER_DEPTH) << (step - SW'(1));
  assign busy       = (step != '0);
  assign in_ready   = !busy && !q_full;
  assign acc        = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_samples <= '0;
      red           <= '0;
      step          <= '0;
    end else if (cfg.we && cfg.index == CFG_DELAY) begin
      delay_samples <= cfg.data[DELAY_W-1:0];
      red           <= CW'(cfg.data[DELAY_W-1:0]);
      step          <= SW'(STEPS);
    end else if (busy) begin
      if (red >= step_const) begin
        red <= red - step_const;
      end
      step <= step - SW'(1);
    end
  end

  // fetch address: write_index - (delay mod depth), wrapped into the buffer
  always_comb begin
    ia = {1'b0, write_index};
    da = {1'b0, red[AW-1:0]};
    if (ia >= da) begin
      fetch = ia - da;
    end else begin
      fetch = ia + (AW+1)'(BUFFER_DEPTH) - da;
    end
  end

  assign before_fill = (IW'(write_index) < IW'(delay_samples));
  // only [0, write_index) has been written until the first wrap
  assign unwritten   = !wrapped && !(fetch[AW-1:0] < write_index);

  // mono = (left + right) / 2, toward zero
  assign sum     = {held_left[SAMPLE_W-1], held_left} + {sample[SAMPLE_W-1], sample};
  assign sum_adj = sum + (SAMPLE_W+1)'(sum[SAMPLE_W]);

  assign push           = acc;
  assign ctl.is_left    = expect_left;
  assign ctl.fetch_zero = expect_left && ((before_fill && !filled_once) || unwritten);
  assign data           = sum_adj[SAMPLE_W:1];
  assign addr           = expect_left ? fetch[AW-1:0] : write_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_left <= 1'b1;
      write_index <= '0;
      filled_once <= 1'b0;
      wrapped     <= 1'b0;
    end else if (acc) begin
      if (expect_left) begin
        expect_left <= 1'b0;
        if (!before_fill) begin
          filled_once <= 1'b1;
        end
      end else begin
        expect_left <= 1'b1;
        if (write_index == AW'(BUFFER_DEPTH - 1)) begin
          write_index <= '0;
          wrapped     <= 1'b1;
        end else begin
          write_index <= write_index + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && expect_left) begin
      held_left <= sample;
    end
  end

endmodule

// ===== hw/rtl/sfe_queue.sv =====
// Four-entry FIFO between front and back ends.
// Depends on nothing but the width parameter.
`timescale 1ns / 1ps

module sfe_queue #(
  parameter int W = 36
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] pop_data
);

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  logic [W-1:0]  entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign full     = (count == (PW+1)'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (PW+1)'(1);
        2'b01:   count <= count - (PW+1)'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/sfe_back.sv =====
// Back end: delay memory, echo mix pipeline and output register.
// Depends on sfe_pkg.
`timescale 1ns / 1ps

module sfe_back #(
  parameter int BUFFER_DEPTH = 262144,
  parameter int AW           = $clog2(BUFFER_DEPTH)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  sfe_pkg::sfe_cfg_t                   cfg,
  input  logic                                q_empty,
  output logic                                pop,
  input  sfe_pkg::sfe_ctl_t                   ctl,
  input  logic signed [sfe_pkg::SAMPLE_W-1:0] data,
  input  logic [AW-1:0]                       addr,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [sfe_pkg::SAMPLE_W-1:0] echo_sample
);
  import sfe_pkg::*;

  localparam int PRODW = SAMPLE_W + 1 + GAIN_W + 1;
  localparam int NUMW  = PRODW + 1;

  logic signed [SAMPLE_W-1:0] store [BUFFER_DEPTH];

  logic [GAIN_W-1:0]          echo_gain;
  logic signed [SAMPLE_W-1:0] rd_data;
  logic                       fetch_zero_q;
  logic                       fwd_hit;
  logic signed [SAMPLE_W-1:0] fwd_data;

  logic                       p_valid;
  logic signed [SAMPLE_W-1:0] p_mono;
  logic signed [PRODW-1:0]    p_prod;
  logic [AW-1:0]              p_addr;

  logic                       m_fire;
  logic signed [SAMPLE_W-1:0] delayed;
  logic signed [SAMPLE_W:0]   diff;
  logic signed [GAIN_W:0]     gain_s;
  logic signed [PRODW-1:0]    prod;
  logic signed [NUMW-1:0]     num;
  logic signed [NUMW-1:0]     num_adj;
  logic signed [SAMPLE_W-1:0] mix;

  assign m_fire = p_valid && (!out_valid || out_ready);
  // a left word may only fetch once any older write is landing this cycle
  assign pop    = !q_empty && (!p_valid || m_fire);

  assign delayed = fetch_zero_q ? '0 : (fwd_hit ? fwd_data : rd_data);

  // mix = (mono*256 + (delayed - mono)*g) / 256, toward zero
  assign diff   = {delayed[SAMPLE_W-1], delayed} - {data[SAMPLE_W-1], data};
  assign gain_s = {1'b0, echo_gain};
  assign prod   = diff * gain_s;

  assign num     = {{(NUMW-SAMPLE_W-8){p_mono[SAMPLE_W-1]}}, p_mono, 8'd0}
                 + {p_prod[PRODW-1], p_prod};
  assign num_adj = num + (num[NUMW-1] ? NUMW'(255) : NUMW'(0));
  assign mix     = num_adj[SAMPLE_W+7:8];

  always_ff @(posedge clk) begin
    if (m_fire) begin
      store[p_addr] <= mix;
    end
    if (pop && ctl.is_left) begin
      rd_data <= store[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pop && ctl.is_left) begin
      fetch_zero_q <= ctl.fetch_zero;
      fwd_hit      <= m_fire && (p_addr == addr);
      fwd_data     <= mix;
    end
    if (pop && !ctl.is_left) begin
      p_mono <= data;
      p_prod <= prod;
      p_addr <= addr;
    end
    if (m_fire) begin
      echo_sample <= mix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      echo_gain <= GAIN_RESET;
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg.we && cfg.index == CFG_GAIN) begin
        echo_gain <= (cfg.data[GAIN_W-1:0] > GAIN_UNITY) ? GAIN_UNITY
                                                         : cfg.data[GAIN_W-1:0];
      end
      if (pop && !ctl.is_left) begin
        p_valid <= 1'b1;
      end else if (m_fire) begin
        p_valid <= 1'b0;
      end
      if (m_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/stereo_to_mono_feedback_echo_unit.sv =====
// Top level of the stereo-to-mono feedback echo.
// Depends on sfe_pkg, sfe_front, sfe_queue and sfe_back.
`timescale 1ns / 1ps

// Usage:
//   Input words (sample) arrive on in_valid/in_ready, alternating left and
//   right, left first after reset. Each right word produces one output word
//   (echo_sample) on out_valid/out_ready; left words produce nothing.
//   Config: cfg_we/cfg_index/cfg_data, written only while the block is idle.
//   A delay write is then reduced modulo the depth by restoring subtraction;
//   in_ready is low meanwhile.
// Throughput: one input word per cycle unless stalled (see Stalls); the delay
//   memory gets one read slot per left word and one write slot per right word.
// Path: an accepted right word passes through the queue and then the multiply
//   stage (p_prod); the add, the memory write and the output register share
//   the final edge.
// Reset: synchronous; clears the channel phase, write pointer, fill flags,
//   config registers and all valids. The delay memory is not swept: entries
//   not yet written since reset are masked to zero by the write pointer and a
//   wrap flag, so no clearing pass is needed.
// Stalls: when out_ready is low the output register holds; the back end then
//   stops, the 4-word queue fills, and in_ready drops once it is full.

module stereo_to_mono_feedback_echo_unit #(
  parameter int BUFFER_DEPTH = 262144
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  sfe_pkg::sfe_reg_t                     cfg_index,
  input  logic [sfe_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [sfe_pkg::SAMPLE_W-1:0]   sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [sfe_pkg::SAMPLE_W-1:0]   echo_sample
);
  import sfe_pkg::*;

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int QW = $bits(sfe_ctl_t) + SAMPLE_W + AW;

  sfe_cfg_t                   cfg;
  logic                       push;
  logic                       q_full;
  logic                       q_empty;
  logic                       pop;
  sfe_ctl_t                   f_ctl;
  logic signed [SAMPLE_W-1:0] f_data;
  logic [AW-1:0]              f_addr;
  sfe_ctl_t                   b_ctl;
  logic signed [SAMPLE_W-1:0] b_data;
  logic [AW-1:0]              b_addr;
  logic [QW-1:0]              q_in;
  logic [QW-1:0]              q_out;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // front: pairing, mono sum, fetch address and zero masking
  sfe_front #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .AW           (AW)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sample   (sample),
    .q_full   (q_full),
    .push     (push),
    .ctl      (f_ctl),
    .data     (f_data),
    .addr     (f_addr)
  );

  assign q_in = {f_ctl, f_data, f_addr};

  sfe_queue #(
    .W (QW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .pop_data  (q_out)
  );

  assign {b_ctl, b_data, b_addr} = q_out;

  // back: delay memory access, mix, write-back and output
  sfe_back #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .AW           (AW)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_empty     (q_empty),
    .pop         (pop),
    .ctl         (b_ctl),
    .data        (b_data),
    .addr        (b_addr),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .echo_sample (echo_sample)
  );

endmodule

// ===== hw/rtl/sfe_checker.sv =====
// Port-level checks for the stereo-to-mono feedback echo, bound to the top level.
// Depends on sfe_pkg and stereo_to_mono_feedback_echo_unit.
`timescale 1ns / 1ps

module sfe_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [sfe_pkg::SAMPLE_W-1:0] echo_sample
);
  import sfe_pkg::*;

  logic       expect_left;
  logic [2:0] pending;
  logic       right_acc;
  logic       out_acc;

  assign right_acc = in_valid && in_ready && !expect_left;
  assign out_acc   = out_valid && out_ready;

  // right words accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      expect_left <= 1'b1;
      pending     <= '0;
    end else begin
      if (in_valid && in_ready) begin
        expect_left <= !expect_left;
      end
      case ({right_acc, out_acc})
        2'b10:   pending <= pending + 3'd1;
        2'b01:   pending <= pending - 3'd1;
        default: pending <= pending;
      endcase
    end
  end

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(echo_sample))
    else $error("stalled output word changed");

  a_out_has_source: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 3'd0)
    else $error("output word without a pending right word");

  a_inflight_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'd4)
    else $error("too many pairs in flight");

endmodule

bind stereo_to_mono_feedback_echo_unit sfe_checker u_sfe_checker (.*);

// ===== bench/tb.sv =====
// Self-checking bench for stereo_to_mono_feedback_echo_unit.
// Depends on sfe_pkg and the RTL top level only; predicts every echo word
// internally and checks each one.
`timescale 1ns / 1ps

module tb;
  import sfe_pkg::*;

  localparam int BUFFER_DEPTH    = 262144;
  localparam int NUM_PHASES      = 8;
  localparam int PAIRS_PER_PHASE = 84;
  localparam int PRESSURE_PHASE  = 4;
  localparam int HOLD_CYCLES     = 400;  // long receiver hold-off
  localparam int SETTLE_CYCLES   = 12;   // exceeds the output path plus queue depth
  localparam int MAX_REPORTS     = 200;

  // Tracks the echo datapath: channel phase, held left word, fetched echo,
  // write pointer, fill flag and the circular delay history. Entries never
  // written read as zero, which matches the RTL masking of unwritten entries.
  class echo_scoreboard;
    logic [DELAY_W-1:0]          delay;
    logic [GAIN_W-1:0]           gain;
    bit                          want_left;
    int                          left_hold;
    int                          fetched;
    int                          wr_ptr;
    bit                          primed;
    logic signed [SAMPLE_W-1:0]  history [int];
    logic signed [SAMPLE_W-1:0]  mix_q [$];
    int                          errors;
    int                          checked;
    int                          taken;

    function new();
      delay     = '0;
      gain      = GAIN_RESET;
      want_left = 1'b1;
      left_hold = 0;
      fetched   = 0;
      wr_ptr    = 0;
      primed    = 1'b0;
      errors    = 0;
      checked   = 0;
      taken     = 0;
    endfunction

    function void write_reg(sfe_reg_t idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_DELAY) delay = data[DELAY_W-1:0];
      else gain = data[GAIN_W-1:0];
    endfunction

    function void note_sample(logic signed [SAMPLE_W-1:0] s);
      int g;
      int mono;
      int mix;
      int addr;
      taken++;
      if (want_left) begin
        want_left = 1'b0;
        left_hold = int'(s);
        // Nothing to echo until the pointer has first reached the delay.
        if (wr_ptr < int'(delay) && !primed) begin
          fetched = 0;
        end else begin
          addr = (wr_ptr + BUFFER_DEPTH - (int'(delay) % BUFFER_DEPTH)) % BUFFER_DEPTH;
          fetched = history.exists(addr) ? int'(history[addr]) : 0;
        end
        if (wr_ptr >= int'(delay)) primed = 1'b1;
      end else begin
        g = (gain > GAIN_UNITY) ? 256 : int'(gain);
        mono = (left_hold + int'(s)) / 2;  // truncates toward zero
        mix = (mono * (256 - g) + fetched * g) / 256;
        if (mix > 32767) mix = 32767;
        if (mix < -32768) mix = -32768;
        want_left = 1'b1;
        history[wr_ptr] = mix[SAMPLE_W-1:0];
        mix_q.push_back(mix[SAMPLE_W-1:0]);
        wr_ptr = (wr_ptr + 1) % BUFFER_DEPTH;
      end
    endfunction

    function void check_echo(logic signed [SAMPLE_W-1:0] got);
      logic signed [SAMPLE_W-1:0] want;
      if (mix_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected echo word, expected none, actual %0d", $time, got);
        return;
      end
      want = mix_q.pop_front();
      checked++;
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: echo_sample mismatch, expected %0d, actual %0d", $time, want, got);
      end
    endfunction
  endclass

  // All block inputs start at known values.
  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_we = 1'b0;
  sfe_reg_t                    cfg_index = CFG_DELAY;
  logic [CFG_DATA_W-1:0]       cfg_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic signed [SAMPLE_W-1:0]  sample = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0]  echo_sample;

  int idle_pct  = 0;    // sender gap chance per cycle
  int stall_pct = 0;    // receiver stall chance per cycle
  bit hold_on   = 1'b0; // long receiver hold-off, toggled on the falling edge

  echo_scoreboard sb = new();

  // Directed words, left then right: full-scale pairs, opposite extremes,
  // odd sums that truncate toward zero on both signs.
  logic signed [SAMPLE_W-1:0] directed_words [24] = '{
    16'sd32767,  16'sd32767,  -16'sd32768, -16'sd32768,
    16'sd32767,  -16'sd32768, -16'sd32768, 16'sd32767,
    -16'sd1,     16'sd0,      -16'sd3,     16'sd0,
    16'sd1,      16'sd0,      16'sd3,      16'sd0,
    16'sd0,      16'sd0,      16'sd12345,  -16'sd12346,
    -16'sd32768, -16'sd32767, 16'sd20000,  16'sd20001
  };

  // Per-phase settings: zero and maximum delay, unity, zero and
  // above-unity gain (which must clamp to unity).
  logic [DELAY_W-1:0] phase_delay [NUM_PHASES] = '{
    18'd0, 18'd1, 18'd262143, 18'd2, 18'd17, 18'd100, 18'd3, 18'd64
  };
  logic [GAIN_W-1:0] phase_gain [NUM_PHASES] = '{
    9'd300, 9'd511, 9'd256, 9'd0, 9'd128, 9'd102, 9'd1, 9'd255
  };

  stereo_to_mono_feedback_echo_unit #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sample      (sample),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .echo_sample (echo_sample)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver: random stalls, plus the long hold-off when requested.
  always @(posedge clk) begin
    out_ready <= !hold_on && ($urandom_range(99) >= stall_pct);
  end

  // Output words are sampled on the falling edge, where every signal is
  // settled; the word is taken at the following rising edge.
  always @(negedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_echo(echo_sample);
  end

  // One register write; cfg_we is dropped and stays low until the task returns, so writes never collide.
  task automatic write_reg(sfe_reg_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  // Offers one word after an optional random gap. Valid stays high across
  // back-to-back words; the caller drops it when the stream ends.
  task automatic send_sample(logic signed [SAMPLE_W-1:0] s);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    sb.note_sample(s);
  endtask

  // Mostly full-range noise, with a good share of rail and near-zero values.
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic send_pairs(int pairs);
    repeat (2 * pairs) send_sample(pick_sample());
  endtask

  // Drain every expected word, then give any trailing left word time to
  // leave the pipeline before touching the registers.
  task automatic settle();
    while (sb.mix_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [CFG_DATA_W-GAIN_W-1:0] junk;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Only the delay is written here so the gain runs at its reset value.
    // A nonzero delay keeps the first fetches in the not-yet-filled state.
    write_reg(CFG_DELAY, 18'd6);
    foreach (directed_words[i]) send_sample(directed_words[i]);

    for (int p = 0; p < NUM_PHASES; p++) begin
      in_valid <= 1'b0;
      settle();
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 56; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 56; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      // Unused upper data bits on a gain write must be ignored.
      junk = (CFG_DATA_W-GAIN_W)'($urandom);
      write_reg(CFG_DELAY, phase_delay[p]);
      write_reg(CFG_GAIN, {junk, phase_gain[p]});
      if (p == PRESSURE_PHASE) begin
        // Receiver holds off while the sender keeps offering: queue fills
        // and in_ready must drop, then everything must come out intact.
        fork
          begin
            @(negedge clk) hold_on = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clk);
            hold_on = 1'b0;
          end
          send_pairs(PAIRS_PER_PHASE);
        join
      end else begin
        send_pairs(PAIRS_PER_PHASE);
      end
    end

    in_valid <= 1'b0;
    settle();

    $display("Covered %0d input words and %0d echo words over %0d register settings,",
             sb.taken, sb.checked, NUM_PHASES + 1);
    $display("including gain clamping, zero and maximum delay, and a stalled receiver.");
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/sfe_pkg.sv
hw/rtl/sfe_front.sv
hw/rtl/sfe_queue.sv
hw/rtl/sfe_back.sv
hw/rtl/stereo_to_mono_feedback_echo_unit.sv
hw/rtl/sfe_checker.sv
bench/tb.sv
